// ===== design/lrupr_pkg.sv =====
// Shared types and constants for the LRU page replacement core.
package lrupr_pkg;

  localparam int unsigned CFG_W       = 7;
  localparam int unsigned PAGE_W      = 16;
  localparam int unsigned FRAME_OUT_W = 6;
  localparam int unsigned FAULT_W     = 32;
  localparam int unsigned MIN_FRAMES  = 2;

  localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_HOLD
  } state_t;

  typedef struct packed {
    logic commit;
    logic load;
  } upd_t;

endpackage

// ===== design/lrupr_cell.sv =====
// One frame cell: holds tag, valid and rank, and passes the search word on.
module lrupr_cell #(
  parameter int unsigned IDX    = 0,
  parameter int unsigned FRAMES = 64,
  parameter int unsigned TAG_W  = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [$clog2(FRAMES+1)-1:0]   n_act,
  input  lrupr_pkg::upd_t               upd,
  input  logic [$clog2(FRAMES)-1:0]     upd_idx,
  input  logic [$clog2(FRAMES)-1:0]     upd_rank,
  input  logic [TAG_W-1:0]              upd_tag,
  input  logic                          v_in,
  input  logic [TAG_W-1:0]              page_in,
  input  logic                          hf_in,
  input  logic [$clog2(FRAMES)-1:0]     hr_in,
  input  logic [$clog2(FRAMES)-1:0]     hi_in,
  input  logic                          lh_in,
  input  logic [$clog2(FRAMES)-1:0]     lr_in,
  input  logic [$clog2(FRAMES)-1:0]     li_in,
  input  logic [TAG_W-1:0]              ltag_in,
  input  logic                          lval_in,
  output logic                          v_out,
  output logic [TAG_W-1:0]              page_out,
  output logic                          hf_out,
  output logic [$clog2(FRAMES)-1:0]     hr_out,
  output logic [$clog2(FRAMES)-1:0]     hi_out,
  output logic                          lh_out,
  output logic [$clog2(FRAMES)-1:0]     lr_out,
  output logic [$clog2(FRAMES)-1:0]     li_out,
  output logic [TAG_W-1:0]              ltag_out,
  output logic                          lval_out
);
  import lrupr_pkg::*;

  localparam int unsigned IDX_W = $clog2(FRAMES);
  localparam int unsigned CNT_W = $clog2(FRAMES+1);

  logic [TAG_W-1:0] tag_r;
  logic             valid_r;
  logic [IDX_W-1:0] rank_r;

  logic             v_r;
  logic [TAG_W-1:0] page_r;
  logic             hf_r;
  logic [IDX_W-1:0] hr_r;
  logic [IDX_W-1:0] hi_r;
  logic             lh_r;
  logic [IDX_W-1:0] lr_r;
  logic [IDX_W-1:0] li_r;
  logic [TAG_W-1:0] ltag_r;
  logic             lval_r;

  logic active;
  logic take_hit;
  logic take_lru;
  logic sel;

  always_comb begin
    active   = (CNT_W'(IDX) < n_act);
    take_hit = active && valid_r && (tag_r == page_in) && (!hf_in || (rank_r < hr_in));
    take_lru = active && (!lh_in || (rank_r < lr_in));
    sel      = (upd_idx == IDX_W'(IDX));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r     <= 1'b0;
      valid_r <= 1'b0;
      rank_r  <= IDX_W'(IDX);
    end else begin
      v_r <= v_in;
      if (upd.commit) begin
        if (sel) begin
          rank_r <= IDX_W'(FRAMES - 1);
          if (upd.load) begin
            valid_r <= 1'b1;
          end
        end else if (rank_r > upd_rank) begin
          rank_r <= rank_r - IDX_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (upd.commit && upd.load && sel) begin
      tag_r <= upd_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (v_in) begin
      page_r <= page_in;
      hf_r   <= hf_in | take_hit;
      hr_r   <= take_hit ? rank_r : hr_in;
      hi_r   <= take_hit ? IDX_W'(IDX) : hi_in;
      lh_r   <= lh_in | take_lru;
      lr_r   <= take_lru ? rank_r : lr_in;
      li_r   <= take_lru ? IDX_W'(IDX) : li_in;
      ltag_r <= take_lru ? tag_r : ltag_in;
      lval_r <= take_lru ? valid_r : lval_in;
    end
  end

  assign v_out    = v_r;
  assign page_out = page_r;
  assign hf_out   = hf_r;
  assign hr_out   = hr_r;
  assign hi_out   = hi_r;
  assign lh_out   = lh_r;
  assign lr_out   = lr_r;
  assign li_out   = li_r;
  assign ltag_out = ltag_r;
  assign lval_out = lval_r;

endmodule

// ===== design/lru_page_replacement_core.sv =====
// Top level: fully associative page table with LRU replacement over a chain of frame cells.
// The result word is registered at the commit, after the search word leaves the last cell.
// A new page word waits until the last one commits; the search word walks the cell chain,
//   one cell per cycle, then all cells update their ranks in one commit, held off by out_stall.
// Reset: all frames empty, rank equals frame index, fault count zero, frames_in_use 64.
// Reset is synchronous and active low.
module lru_page_replacement_core #(
  parameter int unsigned FRAMES    = 64,
  parameter int unsigned PAGE_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [lrupr_pkg::CFG_W-1:0]         cfg_wr_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [lrupr_pkg::PAGE_W-1:0]        in_page_number,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_hit,
  output logic [lrupr_pkg::FRAME_OUT_W-1:0]   out_frame_index,
  output logic                                out_evicted_valid,
  output logic [lrupr_pkg::PAGE_W-1:0]        out_evicted_page,
  output logic [lrupr_pkg::FAULT_W-1:0]       out_fault_total
);
  import lrupr_pkg::*;

  localparam int unsigned IDX_W = $clog2(FRAMES);
  localparam int unsigned CNT_W = $clog2(FRAMES+1);

  logic [CFG_W-1:0]   cfg_r;
  logic [CNT_W-1:0]   n_act;
  state_t             state_r;
  state_t             state_nxt;
  logic [FAULT_W-1:0] fault_r;
  logic [FAULT_W-1:0] fault_nxt;

  logic                   out_valid_r;
  logic                   out_hit_r;
  logic [FRAME_OUT_W-1:0] out_frame_r;
  logic                   out_ev_valid_r;
  logic [PAGE_W-1:0]      out_ev_page_r;

  logic                 accept_in;
  logic                 tail_ready;
  logic                 commit;
  logic                 found;
  logic [IDX_W-1:0]     f_sel;
  logic [IDX_W-1:0]     r_old;
  logic                 ev_valid;
  upd_t                 upd;

  logic [FRAMES:0]      c_v;
  logic [PAGE_BITS-1:0] c_page [FRAMES+1];
  logic                 c_hf   [FRAMES+1];
  logic [IDX_W-1:0]     c_hr   [FRAMES+1];
  logic [IDX_W-1:0]     c_hi   [FRAMES+1];
  logic                 c_lh   [FRAMES+1];
  logic [IDX_W-1:0]     c_lr   [FRAMES+1];
  logic [IDX_W-1:0]     c_li   [FRAMES+1];
  logic [PAGE_BITS-1:0] c_ltag [FRAMES+1];
  logic                 c_lval [FRAMES+1];

  always_comb begin
    if (cfg_r < CFG_W'(MIN_FRAMES)) begin
      n_act = CNT_W'(MIN_FRAMES);
    end else if (32'(cfg_r) > 32'(FRAMES)) begin
      n_act = CNT_W'(FRAMES);
    end else begin
      n_act = CNT_W'(cfg_r);
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign accept_in = in_valid && !in_stall;

  // chain head: fresh search word
  assign c_v[0]    = accept_in;
  assign c_page[0] = PAGE_BITS'(in_page_number);
  assign c_hf[0]   = 1'b0;
  assign c_hr[0]   = '0;
  assign c_hi[0]   = '0;
  assign c_lh[0]   = 1'b0;
  assign c_lr[0]   = '0;
  assign c_li[0]   = '0;
  assign c_ltag[0] = '0;
  assign c_lval[0] = 1'b0;

  for (genvar g = 0; g < FRAMES; g++) begin : g_cell
    lrupr_cell #(
      .IDX    (g),
      .FRAMES (FRAMES),
      .TAG_W  (PAGE_BITS)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .n_act    (n_act),
      .upd      (upd),
      .upd_idx  (f_sel),
      .upd_rank (r_old),
      .upd_tag  (c_page[FRAMES]),
      .v_in     (c_v[g]),
      .page_in  (c_page[g]),
      .hf_in    (c_hf[g]),
      .hr_in    (c_hr[g]),
      .hi_in    (c_hi[g]),
      .lh_in    (c_lh[g]),
      .lr_in    (c_lr[g]),
      .li_in    (c_li[g]),
      .ltag_in  (c_ltag[g]),
      .lval_in  (c_lval[g]),
      .v_out    (c_v[g+1]),
      .page_out (c_page[g+1]),
      .hf_out   (c_hf[g+1]),
      .hr_out   (c_hr[g+1]),
      .hi_out   (c_hi[g+1]),
      .lh_out   (c_lh[g+1]),
      .lr_out   (c_lr[g+1]),
      .li_out   (c_li[g+1]),
      .ltag_out (c_ltag[g+1]),
      .lval_out (c_lval[g+1])
    );
  end

  always_comb begin
    found      = c_hf[FRAMES];
    f_sel      = found ? c_hi[FRAMES] : c_li[FRAMES];
    r_old      = found ? c_hr[FRAMES] : c_lr[FRAMES];
    ev_valid   = !found && c_lval[FRAMES];
    tail_ready = ((state_r == ST_SCAN) && c_v[FRAMES]) || (state_r == ST_HOLD);
    commit     = tail_ready && (!out_valid_r || !out_stall);
    upd.commit = commit;
    upd.load   = !found;
    fault_nxt  = fault_r;
    if (commit && !found && (fault_r != '1)) begin
      fault_nxt = fault_r + FAULT_W'(1);
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept_in) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (c_v[FRAMES]) begin
          state_nxt = commit ? ST_IDLE : ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (commit) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cfg_r       <= CFG_RESET;
      fault_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fault_r <= fault_nxt;
      if (cfg_wr_en) begin
        cfg_r <= cfg_wr_data;
      end
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_hit_r      <= found;
      out_frame_r    <= FRAME_OUT_W'(f_sel);
      out_ev_valid_r <= ev_valid;
      out_ev_page_r  <= ev_valid ? PAGE_W'(c_ltag[FRAMES]) : '0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_hit           = out_hit_r;
  assign out_frame_index   = out_frame_r;
  assign out_evicted_valid = out_ev_valid_r;
  assign out_evicted_page  = out_ev_page_r;
  assign out_fault_total   = fault_r;

`ifndef SYNTHESIS
  a_one_word_in_chain: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(c_v))
    else $error("more than one search word in the cell chain");

  a_tail_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    c_v[FRAMES] |-> (state_r == ST_SCAN))
    else $error("search word left the chain outside the scan state");

  a_fault_monotonic: assert property (@(posedge clk)
    (rst_n && $past(rst_n)) |-> (fault_r >= $past(fault_r)))
    else $error("fault count decreased");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_hit_r) |-> !out_ev_valid_r)
    else $error("hit word reports an eviction");
`endif

endmodule
